FILE: hw/rtl/olasr_pkg.sv
package olasr_pkg;

    // Default sizing of the list.
    localparam int OLASR_DEPTH       = 64;
    localparam int OLASR_VALUE_WIDTH = 32;

    // Fixed widths of the command and result words.
    localparam int OLASR_VALUE_BITS = 32;
    localparam int OLASR_COUNT_BITS = 7;

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_CONTAINS = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_CLEAR    = 2'd3
    } olasr_cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } olasr_state_t;

    typedef struct packed {
        olasr_cmd_t                  command;
        logic [OLASR_VALUE_BITS-1:0] value;
    } olasr_in_t;

    typedef struct packed {
        logic                        hit;
        logic                        full_drop;
        logic [OLASR_COUNT_BITS-1:0] count;
    } olasr_out_t;

endpackage

FILE: hw/rtl/ordered_list_append_search_remove.sv
// Ordered list of up to DEPTH values kept in insertion order. A command word
// is taken at a rising edge where start is high and busy is low. Append and
// clear finish at once: their result word appears on result, marked by done,
// in the cycle after the command is taken, and busy stays low, so a new
// command may follow every cycle. Contains and remove walk the stored entries
// through the single read port of the entry memory, one entry per cycle,
// with busy high until every stored entry has been compared; the result
// appears, marked by done, in the first cycle in which busy is low again.
// Contains or remove on an empty list finishes like an append. The result is
// shown for exactly one cycle and cannot be held off, so the receiver must
// take it whenever done is high.
module ordered_list_append_search_remove
    import olasr_pkg::*;
#(
    parameter int DEPTH       = OLASR_DEPTH,
    parameter int VALUE_WIDTH = OLASR_VALUE_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  olasr_in_t  request,
    output logic       busy,
    output logic       done,
    output olasr_out_t result
);

    // Values are compared over their low VALUE_WIDTH bits, and never over
    // more than the width of the command value field.
    localparam int SW = (VALUE_WIDTH < OLASR_VALUE_BITS) ? VALUE_WIDTH : OLASR_VALUE_BITS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] mem_rdata;

    // The sequencer owns the count and drives the memory. During a remove
    // it reads one entry per cycle and, once the match has been passed,
    // writes each following entry one slot lower, so the search and the
    // compaction share a single pass.
    olasr_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .SW          (SW),
        .AW          (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // The entry store needs no reset: only slots below the count are read,
    // and each of them was written first.
    olasr_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (SW),
        .AW         (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: hw/rtl/olasr_mem.sv
module olasr_mem
    import olasr_pkg::*;
#(
    parameter int DEPTH      = OLASR_DEPTH,
    parameter int DATA_WIDTH = OLASR_VALUE_WIDTH,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    // Simple dual-port storage with a registered read.
    logic [DATA_WIDTH-1:0] ram_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/olasr_seq.sv
module olasr_seq
    import olasr_pkg::*;
#(
    parameter int DEPTH       = OLASR_DEPTH,
    parameter int VALUE_WIDTH = OLASR_VALUE_WIDTH,
    parameter int SW = (VALUE_WIDTH < OLASR_VALUE_BITS) ? VALUE_WIDTH : OLASR_VALUE_BITS,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  olasr_in_t       request,
    output logic            busy,
    output logic            done,
    output olasr_out_t      result,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output logic [SW-1:0]   mem_wdata,
    output logic            mem_re,
    output logic [AW-1:0]   mem_raddr,
    input  logic [SW-1:0]   mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);

    olasr_state_t state_reg, state_next;

    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]               ridx_reg, ridx_next;
    logic                        rv_reg, rv_next;
    logic                        found_reg, found_next;
    logic                        remove_reg, remove_next;
    logic [SW-1:0]               key_reg, key_next;
    logic                        done_reg, done_next;
    logic                        hit_reg, hit_next;
    logic                        drop_reg, drop_next;
    logic [OLASR_COUNT_BITS-1:0] rcount_reg, rcount_next;

    logic          accept;
    logic          scan_cmd;
    logic          match;
    logic          last;
    logic [CW-1:0] ridx_prev;

    assign accept    = start && (state_reg == ST_IDLE);
    assign scan_cmd  = (request.command == CMD_CONTAINS) || (request.command == CMD_REMOVE);
    assign match     = (mem_rdata == key_reg);
    assign last      = rv_reg && (ridx_reg == (count_reg - CW'(1)));
    assign ridx_prev = ridx_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && scan_cmd && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        ridx_next   = ridx_reg;
        rv_next     = 1'b0;
        found_next  = found_reg;
        remove_next = remove_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        drop_next   = drop_reg;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_wdata   = request.value[SW-1:0];
        mem_re      = 1'b0;
        mem_raddr   = rd_ptr_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next  = 1'b0;
                    drop_next = 1'b0;
                    case (request.command)
                        CMD_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg < CW'(DEPTH))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        CMD_CONTAINS, CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                key_next    = request.value[SW-1:0];
                                remove_next = (request.command == CMD_REMOVE);
                                rd_ptr_next = '0;
                                found_next  = 1'b0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle until every entry has been fetched.
                if (rd_ptr_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    rv_next     = 1'b1;
                    ridx_next   = rd_ptr_reg;
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                // Compare the returning entry, or move it down one slot once
                // the match of a remove has been passed.
                if (rv_reg)
                begin
                    if (!found_reg)
                    begin
                        found_next = match;
                    end
                    else if (remove_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ridx_prev[AW-1:0];
                        mem_wdata = mem_rdata;
                    end
                end
                if (last)
                begin
                    done_next = 1'b1;
                    hit_next  = found_reg || match;
                    if (remove_reg && (found_reg || match))
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        rcount_next = done_next ? OLASR_COUNT_BITS'(count_next) : rcount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        ridx_reg   <= ridx_next;
        found_reg  <= found_next;
        remove_reg <= remove_next;
        key_reg    <= key_next;
        hit_reg    <= hit_next;
        drop_reg   <= drop_next;
        rcount_reg <= rcount_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign result.hit       = hit_reg;
    assign result.full_drop = drop_reg;
    assign result.count     = rcount_reg;

    // The entry count never goes past the capacity of the list.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // During a scan the count only changes when the scan finishes.
    a_count_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && $past(state_reg == ST_SCAN) && !$past(last)
        |-> $stable(count_reg))
        else $error("count changed in the middle of a scan");

    // During a scan the memory is written only to close the gap of a remove.
    a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && mem_we |-> found_reg && remove_reg && rv_reg)
        else $error("write during scan without a removed match");

    // The read pointer never runs past the valid entries.
    a_rd_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> rd_ptr_reg <= count_reg)
        else $error("read pointer beyond entry count");

    // The end of a scan always raises the result strobe and frees the block.
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && last |=> done_reg && (state_reg == ST_IDLE))
        else $error("scan ended without a result");

endmodule
